/* rtl/core/sfkt_pkg.sv */
// sfkt_pkg: sizes, operation and status codes, and the cell command struct
// for the sorted field key table. No dependencies.
package sfkt_pkg;

  localparam int MAX_FIELDS = 32;
  localparam int KEY_WIDTH  = 32;
  localparam int SLOT_W     = $clog2(MAX_FIELDS);
  localparam int CNT_W      = $clog2(MAX_FIELDS + 1);
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 3;

  // operation codes
  localparam logic [KIND_W-1:0] OP_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd4;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic                 cmp;
    logic                 ins;
    logic                 rem;
    logic [KEY_WIDTH-1:0] key;
    logic [SLOT_W-1:0]    rslot;
    logic [SLOT_W-1:0]    mpos;
    logic [CNT_W-1:0]     count;
  } cell_cmd_t;

endpackage

/* rtl/core/sfkt_req_if.sv */
// sfkt_req_if: request channel of the sorted field key table.
// Depends on sfkt_pkg.
interface sfkt_req_if;
  import sfkt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [KEY_WIDTH-1:0] key;
  logic [SLOT_W-1:0]    slot;

  modport source(output valid, output kind, output key, output slot, input ready);
  modport sink(input valid, input kind, input key, input slot, output ready);
endinterface

/* rtl/core/sfkt_rsp_if.sv */
// sfkt_rsp_if: response channel of the sorted field key table.
// Depends on sfkt_pkg.
interface sfkt_rsp_if;
  import sfkt_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] slot_index;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  count;

  modport source(output valid, output found, output slot_index, output status,
                 output count, input ready);
  modport sink(input valid, input found, input slot_index, input status,
               input count, output ready);
endinterface

/* rtl/core/sfkt_cell.sv */
// sfkt_cell: one position of the table. Holds one sorted entry (key, slot)
// and one slot-order key, and shifts with its neighbors. Depends on sfkt_pkg.
module sfkt_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  sfkt_pkg::cell_cmd_t           cmd,
  input  logic [sfkt_pkg::KEY_WIDTH-1:0] prev_key,
  input  logic [sfkt_pkg::SLOT_W-1:0]    prev_slot,
  input  logic                          prev_lt,
  input  logic [sfkt_pkg::KEY_WIDTH-1:0] next_key,
  input  logic [sfkt_pkg::SLOT_W-1:0]    next_slot,
  input  logic [sfkt_pkg::KEY_WIDTH-1:0] next_byslot,
  output logic [sfkt_pkg::KEY_WIDTH-1:0] skey,
  output logic [sfkt_pkg::SLOT_W-1:0]    sslot,
  output logic [sfkt_pkg::KEY_WIDTH-1:0] byslot,
  output logic                          lt,
  output logic                          eq,
  output logic                          match
);
  import sfkt_pkg::*;

  localparam logic [CNT_W-1:0]  IDX_C = CNT_W'(IDX);
  localparam logic [SLOT_W-1:0] IDX_S = SLOT_W'(IDX);

  logic              held;
  logic              head;
  logic [SLOT_W-1:0] own_adj;
  logic [SLOT_W-1:0] next_adj;

  assign held     = IDX_C < cmd.count;
  assign head     = (IDX == 0) || prev_lt;
  assign own_adj  = (sslot > cmd.rslot) ? sslot - 1'b1 : sslot;
  assign next_adj = (next_slot > cmd.rslot) ? next_slot - 1'b1 : next_slot;

  // compare flags against the broadcast key and slot
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      lt    <= held && (skey < cmd.key);
      eq    <= held && (skey == cmd.key);
      match <= held && (sslot == cmd.rslot);
    end
  end

  // sorted entry: insert shifts up from the insertion point, remove shifts down and renumbers higher slots
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      skey  <= head ? cmd.key : prev_key;
      sslot <= head ? cmd.count[SLOT_W-1:0] : prev_slot;
    end else if (cmd.rem) begin
      if (IDX_S >= cmd.mpos) begin
        skey  <= next_key;
        sslot <= next_adj;
      end else begin
        sslot <= own_adj;
      end
    end
  end

  // slot-order key
  always_ff @(posedge clk) begin
    if (cmd.ins && (IDX_C == cmd.count)) begin
      byslot <= cmd.key;
    end else if (cmd.rem && (IDX_S >= cmd.rslot)) begin
      byslot <= next_byslot;
    end
  end

endmodule

/* rtl/core/sorted_field_key_table_core.sv */
// sorted_field_key_table_core: controller and row of table cells.
// Depends on sfkt_pkg, sfkt_req_if, sfkt_rsp_if and sfkt_cell.

// Field key table holding up to 32 unsigned 32-bit keys, kept both in slot
// order and in key order inside a row of cells, one cell per position. Every
// operation (append, lookup, remove) runs a broadcast compare in all cells, a
// reduction of the cell flags, then any shift of the row together with the
// result register, which waits until that register is free. One transaction is
// in flight at a time: a new request is taken only after the last one reaches
// the result register, and it may be accepted while that result still waits.
// A duplicate append, an append to a full table and a remove of a slot at or
// above the count are refused with a status and change nothing.
module sorted_field_key_table_core (
  input  logic      clk,
  input  logic      rst,
  sfkt_req_if.sink  req,
  sfkt_rsp_if.source rsp
);
  import sfkt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_RED   = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [KIND_W-1:0]    op;
  logic [KEY_WIDTH-1:0] op_key;
  logic [SLOT_W-1:0]    op_slot;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  logic [SLOT_W-1:0]    mpos;

  logic                 out_valid;
  logic                 out_valid_next;
  logic                 out_found;
  logic [SLOT_W-1:0]    out_slot;
  logic [STAT_W-1:0]    out_status;
  logic [CNT_W-1:0]     out_count;

  logic                 out_free;
  logic                 apply_go;
  logic                 red_hit;
  logic [SLOT_W-1:0]    red_slot;
  logic [SLOT_W-1:0]    red_mpos;
  logic                 res_found;
  logic [SLOT_W-1:0]    res_slot;
  logic [STAT_W-1:0]    res_status;
  logic                 do_ins;
  logic                 do_rem;
  cell_cmd_t            cmd;

  logic [KEY_WIDTH-1:0] c_key    [MAX_FIELDS];
  logic [SLOT_W-1:0]    c_slot   [MAX_FIELDS];
  logic [KEY_WIDTH-1:0] c_byslot [MAX_FIELDS];
  logic [MAX_FIELDS-1:0] c_lt;
  logic [MAX_FIELDS-1:0] c_eq;
  logic [MAX_FIELDS-1:0] c_match;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;
  assign apply_go  = (state == S_APPLY) && out_free;

  // row of cells
  for (genvar i = 0; i < MAX_FIELDS; i++) begin : g_cell
    localparam int PI = (i == 0) ? 0 : i - 1;
    localparam int NI = (i == MAX_FIELDS - 1) ? i : i + 1;
    sfkt_cell #(.IDX(i)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .prev_key    (c_key[PI]),
      .prev_slot   (c_slot[PI]),
      .prev_lt     ((i == 0) ? 1'b0 : c_lt[PI]),
      .next_key    (c_key[NI]),
      .next_slot   (c_slot[NI]),
      .next_byslot (c_byslot[NI]),
      .skey        (c_key[i]),
      .sslot       (c_slot[i]),
      .byslot      (c_byslot[i]),
      .lt          (c_lt[i]),
      .eq          (c_eq[i]),
      .match       (c_match[i])
    );
  end

  // reduce the cell flags: at most one key equal and one slot matching
  always_comb begin
    red_hit  = |c_eq;
    red_slot = '0;
    red_mpos = '0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      red_slot = red_slot | (c_slot[i] & {SLOT_W{c_eq[i]}});
      red_mpos = red_mpos | (SLOT_W'(i) & {SLOT_W{c_match[i]}});
    end
  end

  // decide the outcome of the transaction
  always_comb begin
    res_found  = 1'b0;
    res_slot   = '0;
    res_status = STAT_NOT_FOUND;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    count_next = count;
    case (op)
      OP_APPEND: begin
        if (hit) begin
          res_status = STAT_DUPLICATE;
        end else if (count >= CNT_W'(MAX_FIELDS)) begin
          res_status = STAT_FULL;
        end else begin
          do_ins     = 1'b1;
          res_found  = 1'b1;
          res_slot   = count[SLOT_W-1:0];
          res_status = STAT_OK;
          count_next = count + 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res_found  = 1'b1;
          res_slot   = hit_slot;
          res_status = STAT_OK;
        end
      end
      OP_REMOVE: begin
        if (CNT_W'(op_slot) >= count) begin
          res_status = STAT_RANGE;
        end else begin
          do_rem     = 1'b1;
          res_found  = 1'b1;
          res_slot   = op_slot;
          res_status = STAT_OK;
          count_next = count - 1'b1;
        end
      end
      default: begin
        res_status = STAT_NOT_FOUND;
      end
    endcase
  end

  // command broadcast to the cells
  always_comb begin
    cmd.cmp   = (state == S_CMP);
    cmd.ins   = apply_go && do_ins;
    cmd.rem   = apply_go && do_rem;
    cmd.key   = op_key;
    cmd.rslot = op_slot;
    cmd.mpos  = mpos;
    cmd.count = count;
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_CMP;
      end
      S_CMP:   state_next = S_RED;
      S_RED:   state_next = S_APPLY;
      S_APPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (rsp.ready) out_valid_next = 1'b0;
    if (apply_go) out_valid_next = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (apply_go) count <= count_next;
    end
  end

  // request capture, reduction results and result register
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op      <= req.kind;
      op_key  <= req.key;
      op_slot <= req.slot;
    end
    if (state == S_RED) begin
      hit      <= red_hit;
      hit_slot <= red_slot;
      mpos     <= red_mpos;
    end
    if (apply_go) begin
      out_found  <= res_found;
      out_slot   <= res_slot;
      out_status <= res_status;
      out_count  <= count_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.slot_index = out_slot;
  assign rsp.status     = out_status;
  assign rsp.count      = out_count;

endmodule
